>>> rtl/spapf_pkg.sv
// Package for the source-prefix allowlist packet filter.
// Holds the word, result and search-query types, codes and the prefix mask function.
// Depends on nothing; every other file imports it.
package spapf_pkg;

  // Command codes carried in the command field of an input word.
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Reason codes given with each verdict.
  localparam logic [2:0] RSN_DISABLED  = 3'd0;
  localparam logic [2:0] RSN_TRUNCATED = 3'd1;
  localparam logic [2:0] RSN_ARP       = 3'd2;
  localparam logic [2:0] RSN_V4_ALLOW  = 3'd3;
  localparam logic [2:0] RSN_V4_DENY   = 3'd4;
  localparam logic [2:0] RSN_V6_ALLOW  = 3'd5;
  localparam logic [2:0] RSN_V6_DENY   = 3'd6;
  localparam logic [2:0] RSN_UNKNOWN   = 3'd7;

  // EtherType values and protocol numbers.
  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Minimum frame lengths and longest usable prefixes.
  localparam logic [16:0] MIN_ETH_LEN  = 17'd14;
  localparam logic [16:0] MIN_IPV4_LEN = 17'd34;
  localparam logic [16:0] MIN_IPV6_LEN = 17'd54;
  localparam logic [7:0]  V4_MAX_PREFIX = 8'd32;
  localparam logic [7:0]  V6_MAX_PREFIX = 8'd128;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // One input word.
  typedef struct packed {
    logic        command;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [7:0]  entry_slot;
    logic        entry_valid;
    logic        entry_family_v6;
    logic [7:0]  entry_prefix_len;
    logic [63:0] entry_addr_high;
    logic [63:0] entry_addr_low;
    logic        entry_allow;
  } in_t;

  // One result word.
  typedef struct packed {
    logic        verdict;
    logic [2:0]  reason;
    logic [31:0] source_v4;
    logic [15:0] dest_port;
    logic [7:0]  ip_protocol;
    logic [31:0] packets_seen;
    logic [31:0] packets_allowed;
    logic [31:0] packets_dropped;
    logic [31:0] arp_passed;
  } out_t;

  // Search query and best match so far, handed from cell to cell.
  typedef struct packed {
    logic        valid;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        found;
    logic [7:0]  best_len;
    logic        best_allow;
  } query_t;

  // Mask with the top n bits set; n of 64 or more gives all ones.
  function automatic logic [63:0] top_mask(input logic [7:0] n);
    logic [63:0] ones;
    ones = '1;
    if (n >= 8'd64) begin
      return ones;
    end
    return ~(ones >> n[5:0]);
  endfunction

endpackage

>>> rtl/spapf_cell.sv
// One allowlist slot of the search chain: holds the entry and refines the best match.
// Depends on spapf_pkg.
module spapf_cell
  import spapf_pkg::*;
#(
  parameter int SLOT_INDEX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  in_t    wr,
  input  query_t q_in,
  output query_t q_out
);

  localparam logic [11:0] IDX = 12'(SLOT_INDEX);

  logic        ent_valid;
  logic        ent_v6;
  logic        ent_allow;
  logic [7:0]  ent_len;
  logic [63:0] ent_hi;
  logic [63:0] ent_lo;
  logic        sel;
  logic [63:0] mask_hi;
  logic [63:0] mask_lo;
  logic        in_range;
  logic        hit;
  logic        better;

  assign sel = wr_en && ({4'd0, wr.entry_slot} == IDX);

  // Only the valid flag is cleared by reset; the other entry fields are only read once written.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (sel) begin
      ent_valid <= wr.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      ent_v6    <= wr.entry_family_v6;
      ent_allow <= wr.entry_allow;
      ent_len   <= wr.entry_prefix_len;
      ent_hi    <= wr.entry_addr_high;
      ent_lo    <= wr.entry_addr_low;
    end
  end

  // Prefix compare for the family of the query.
  always_comb begin
    if (q_in.v6) begin
      in_range = (ent_len <= V6_MAX_PREFIX);
      mask_hi  = top_mask(ent_len);
      mask_lo  = (ent_len > 8'd64) ? top_mask(ent_len - 8'd64) : 64'd0;
    end else begin
      in_range = (ent_len <= V4_MAX_PREFIX);
      mask_hi  = top_mask(ent_len) & 64'hFFFF_FFFF_0000_0000;
      mask_lo  = 64'd0;
    end
    hit = ent_valid && (ent_v6 == q_in.v6) && in_range &&
          (((q_in.hi ^ ent_hi) & mask_hi) == 64'd0) &&
          (((q_in.lo ^ ent_lo) & mask_lo) == 64'd0);
    // A strictly longer prefix wins, so the lowest slot keeps a tie.
    better = hit && (!q_in.found || (ent_len > q_in.best_len));
  end

  // Pass the query on, updated with this slot's entry; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else begin
      q_out.valid <= q_in.valid;
    end
    q_out.v6 <= q_in.v6;
    q_out.hi <= q_in.hi;
    q_out.lo <= q_in.lo;
    if (better) begin
      q_out.found      <= 1'b1;
      q_out.best_len   <= ent_len;
      q_out.best_allow <= ent_allow;
    end else begin
      q_out.found      <= q_in.found;
      q_out.best_len   <= q_in.best_len;
      q_out.best_allow <= q_in.best_allow;
    end
  end

endmodule

>>> rtl/source_prefix_allowlist_packet_filter.sv
// Top level of the source-prefix allowlist packet filter: frame parser, counters, control.
// Depends on spapf_pkg and spapf_cell.
//
//  channel   | signals                        | handshake
//  ----------+--------------------------------+--------------------------------------
//  input     | start, busy, request (in_t)    | word taken when start high, busy low
//  result    | result_valid, result (out_t)   | one-cycle strobe, cannot be held off
//  config    | cfg_we, cfg_data               | written when cfg_we high
//
// Frame bytes and table writes are accepted while busy is low. The last byte of an IPv4
// or IPv6 frame that needs a lookup sends the source address down a chain of TABLE_SLOTS
// cells, one cell per cycle; busy stays high while the search runs and the result word
// appears in the cycle busy falls.
// Every other last byte gives its result in the next cycle.
// Reset clears the table's valid flags at once, sets the filter enable and clears
// the counters. The receiver cannot stall the block.
module source_prefix_allowlist_packet_filter
  import spapf_pkg::*;
#(
  parameter int TABLE_SLOTS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic result_valid,
  output out_t result,
  input  logic cfg_we,
  input  logic cfg_data
);

  state_t state;
  state_t state_next;

  logic        filter_enable;
  logic [15:0] byte_pos;
  logic [15:0] ether_type;
  logic [3:0]  header_words;
  logic [7:0]  cap_proto;
  logic [63:0] cap_hi;
  logic [63:0] cap_lo;
  logic [15:0] cap_port;
  logic [31:0] cnt_seen;
  logic [31:0] cnt_allowed;
  logic [31:0] cnt_dropped;
  logic [31:0] cnt_arp;

  logic [15:0] ether_type_next;
  logic [3:0]  header_words_next;
  logic [7:0]  cap_proto_next;
  logic [63:0] cap_hi_next;
  logic [63:0] cap_lo_next;
  logic [15:0] cap_port_next;

  logic        ctx_v6;
  logic [31:0] ctx_src4;
  logic [15:0] ctx_port;
  logic [7:0]  ctx_proto;

  logic        accept;
  logic        frame_acc;
  logic        last_byte;
  logic [16:0] frame_len;
  logic [15:0] port_pos;
  logic        need_lookup;
  logic        port_ok;
  logic        imm_verdict;
  logic [2:0]  imm_reason;
  logic        imm_seen;
  logic        imm_dropped;
  logic        imm_arp;
  logic        allowed;

  query_t links [TABLE_SLOTS+1];
  query_t tail;

  assign accept    = start && !busy;
  assign frame_acc = accept && (request.command == CMD_FRAME);
  assign last_byte = frame_acc && request.frame_end;
  assign frame_len = {1'b0, byte_pos} + 17'd1;
  assign tail      = links[TABLE_SLOTS];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
    end else if (cfg_we) begin
      filter_enable <= cfg_data;
    end
  end

  // Header capture for the current byte.
  always_comb begin
    ether_type_next   = ether_type;
    header_words_next = header_words;
    cap_proto_next    = cap_proto;
    cap_hi_next       = cap_hi;
    cap_lo_next       = cap_lo;
    cap_port_next     = cap_port;
    if (byte_pos == 16'd12) ether_type_next[15:8] = request.frame_byte;
    if (byte_pos == 16'd13) ether_type_next[7:0]  = request.frame_byte;
    if (byte_pos == 16'd14) header_words_next     = request.frame_byte[3:0];
    if (byte_pos == 16'd23) cap_proto_next        = request.frame_byte;
    port_pos = 16'd16 + {10'd0, header_words_next, 2'b00};
    if (ether_type_next == ET_IPV4) begin
      if (byte_pos == 16'd26) cap_hi_next[63:56] = request.frame_byte;
      if (byte_pos == 16'd27) cap_hi_next[55:48] = request.frame_byte;
      if (byte_pos == 16'd28) cap_hi_next[47:40] = request.frame_byte;
      if (byte_pos == 16'd29) cap_hi_next[39:32] = request.frame_byte;
      if (byte_pos == port_pos) cap_port_next[15:8] = request.frame_byte;
      if (byte_pos == port_pos + 16'd1) cap_port_next[7:0] = request.frame_byte;
    end else if (ether_type_next == ET_IPV6) begin
      if (byte_pos >= 16'd22 && byte_pos <= 16'd29) begin
        cap_hi_next = {cap_hi[55:0], request.frame_byte};
      end
      if (byte_pos >= 16'd30 && byte_pos <= 16'd37) begin
        cap_lo_next = {cap_lo[55:0], request.frame_byte};
      end
    end
  end

  // Parser registers; the frame's last byte clears them.
  always_ff @(posedge clk) begin
    if (rst || last_byte) begin
      byte_pos     <= '0;
      ether_type   <= '0;
      header_words <= '0;
      cap_proto    <= '0;
      cap_hi       <= '0;
      cap_lo       <= '0;
      cap_port     <= '0;
    end else if (frame_acc) begin
      if (byte_pos != 16'hFFFF) byte_pos <= byte_pos + 16'd1;
      ether_type   <= ether_type_next;
      header_words <= header_words_next;
      cap_proto    <= cap_proto_next;
      cap_hi       <= cap_hi_next;
      cap_lo       <= cap_lo_next;
      cap_port     <= cap_port_next;
    end
  end

  // Classification of a frame at its last byte.
  always_comb begin
    need_lookup = 1'b0;
    imm_verdict = 1'b0;
    imm_reason  = RSN_TRUNCATED;
    imm_seen    = 1'b0;
    imm_dropped = 1'b0;
    imm_arp     = 1'b0;
    port_ok     = ((cap_proto_next == PROTO_TCP) || (cap_proto_next == PROTO_UDP)) &&
                  (frame_len >= 17'd18 + {11'd0, header_words_next, 2'b00});
    if (!filter_enable) begin
      imm_verdict = 1'b1;
      imm_reason  = RSN_DISABLED;
    end else if (frame_len < MIN_ETH_LEN) begin
      imm_reason = RSN_TRUNCATED;
    end else if (ether_type_next == ET_ARP) begin
      imm_verdict = 1'b1;
      imm_reason  = RSN_ARP;
      imm_arp     = 1'b1;
    end else if (ether_type_next == ET_IPV4) begin
      need_lookup = (frame_len >= MIN_IPV4_LEN);
    end else if (ether_type_next == ET_IPV6) begin
      need_lookup = (frame_len >= MIN_IPV6_LEN);
    end else begin
      imm_reason  = RSN_UNKNOWN;
      imm_seen    = 1'b1;
      imm_dropped = 1'b1;
    end
  end

  // Query injected at the head of the chain.
  always_comb begin
    links[0].valid      = last_byte && need_lookup;
    links[0].v6         = (ether_type_next == ET_IPV6);
    links[0].hi         = cap_hi_next;
    links[0].lo         = cap_lo_next;
    links[0].found      = 1'b0;
    links[0].best_len   = '0;
    links[0].best_allow = 1'b0;
  end

  // Search chain, one cell per table slot.
  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    spapf_cell #(
      .SLOT_INDEX(i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .wr_en(accept && (request.command == CMD_WRITE)),
      .wr   (request),
      .q_in (links[i]),
      .q_out(links[i+1])
    );
  end

  // Frame context kept while the search runs.
  always_ff @(posedge clk) begin
    if (links[0].valid) begin
      ctx_v6    <= links[0].v6;
      ctx_src4  <= links[0].v6 ? 32'd0 : cap_hi_next[63:32];
      ctx_port  <= (!links[0].v6 && port_ok) ? cap_port_next : 16'd0;
      ctx_proto <= links[0].v6 ? 8'd0 : cap_proto_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (links[0].valid) state_next = ST_SEARCH;
      ST_SEARCH: if (tail.valid) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    case (state)
      ST_SEARCH: busy = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign allowed = tail.found && tail.best_allow;

  // Counters and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_seen     <= '0;
      cnt_allowed  <= '0;
      cnt_dropped  <= '0;
      cnt_arp      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (tail.valid) begin
        cnt_seen     <= cnt_seen + 32'd1;
        cnt_allowed  <= cnt_allowed + {31'd0, allowed};
        cnt_dropped  <= cnt_dropped + {31'd0, !allowed};
        result_valid <= 1'b1;
      end else if (last_byte && !need_lookup) begin
        cnt_seen     <= cnt_seen + {31'd0, imm_seen};
        cnt_dropped  <= cnt_dropped + {31'd0, imm_dropped};
        cnt_arp      <= cnt_arp + {31'd0, imm_arp};
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      result.verdict         <= allowed;
      result.reason          <= ctx_v6 ? (allowed ? RSN_V6_ALLOW : RSN_V6_DENY)
                                       : (allowed ? RSN_V4_ALLOW : RSN_V4_DENY);
      result.source_v4       <= ctx_src4;
      result.dest_port       <= ctx_port;
      result.ip_protocol     <= ctx_proto;
      result.packets_seen    <= cnt_seen + 32'd1;
      result.packets_allowed <= cnt_allowed + {31'd0, allowed};
      result.packets_dropped <= cnt_dropped + {31'd0, !allowed};
      result.arp_passed      <= cnt_arp;
    end else if (last_byte) begin
      result.verdict         <= imm_verdict;
      result.reason          <= imm_reason;
      result.source_v4       <= '0;
      result.dest_port       <= '0;
      result.ip_protocol     <= '0;
      result.packets_seen    <= cnt_seen + {31'd0, imm_seen};
      result.packets_allowed <= cnt_allowed;
      result.packets_dropped <= cnt_dropped + {31'd0, imm_dropped};
      result.arp_passed      <= cnt_arp + {31'd0, imm_arp};
    end
  end

`ifndef SYNTHESIS
  // A search leaves the chain only while the controller waits for it.
  a_tail_in_search: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> busy) else $error("search result outside a search");

  // A query enters the chain only when the block is free.
  a_inject_idle: assert property (@(posedge clk) disable iff (rst)
    links[0].valid |-> !busy) else $error("query injected while busy");

  // The end of a search always produces a result word.
  a_search_result: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> result_valid)
    else $error("search ended without a result");
`endif

endmodule
